### hdl/far_pkg.sv
// Shared types and constants for the fraction arithmetic reduce block.
package far_pkg;
  localparam int OperandWidthDefault = 16;
  localparam int OutWidth = 33;
  localparam int RawWidth = 64;
  localparam int CountWidth = 7;

  typedef enum logic [1:0] {
    FUNC_ADD = 2'd0,
    FUNC_SUB = 2'd1,
    FUNC_MUL = 2'd2,
    FUNC_DIV = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_COMB,
    ST_TEST,
    ST_DIVSTART,
    ST_DIVRUN,
    ST_EUCLID,
    ST_CHECKG,
    ST_QNUM,
    ST_QNUM_RUN,
    ST_QDEN,
    ST_QDEN_RUN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic comb;
    logic div_init_rem;
    logic div_init_num;
    logic div_init_den;
    logic div_step;
    logic euclid_swap;
    logic store_num;
    logic store_den;
    logic set_flag;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic y_zero;
    logic g_zero;
    logic g_one;
    logic div_done;
  } status_t;
endpackage

### hdl/fraction_arithmetic_reduce_top.sv
// Top level: an item is accepted and its raw numerator and denominator are formed, then
// Euclid remainder steps run until the remainder is zero, followed by the final zero test
// and gcd check, the two exact divisions by g when g is neither 0 nor 1, and the load of
// the output register, which waits while a held result is stalled. All divisions use the
// single 64-step restoring divider. One item is in work at a time, a result waits in an
// output register.
module fraction_arithmetic_reduce_top
  import far_pkg::*;
#(
  parameter int OPERAND_WIDTH = OperandWidthDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] func,
  input  logic signed [OPERAND_WIDTH-1:0] num_a,
  input  logic signed [OPERAND_WIDTH-1:0] den_a,
  input  logic signed [OPERAND_WIDTH-1:0] num_b,
  input  logic signed [OPERAND_WIDTH-1:0] den_b,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [OutWidth-1:0] result_num,
  output logic signed [OutWidth-1:0] result_den,
  output logic gcd_zero
);
  cmd_t cmd;
  status_t status;

  far_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .status(status), .cmd(cmd)
  );

  far_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status), .func(func),
    .num_a(num_a), .den_a(den_a), .num_b(num_b), .den_b(den_b),
    .result_num(result_num), .result_den(result_den), .gcd_zero(gcd_zero)
  );
endmodule

### hdl/far_datapath.sv
// Datapath: operand registers, multiplier, shared restoring divider, Euclid registers.
module far_datapath
  import far_pkg::*;
#(
  parameter int OPERAND_WIDTH = OperandWidthDefault
) (
  input  logic                       clk,
  input  logic                       rst,
  input  cmd_t                       cmd,
  output status_t                    status,
  input  logic [1:0]                 func,
  input  logic signed [OPERAND_WIDTH-1:0] num_a,
  input  logic signed [OPERAND_WIDTH-1:0] den_a,
  input  logic signed [OPERAND_WIDTH-1:0] num_b,
  input  logic signed [OPERAND_WIDTH-1:0] den_b,
  output logic signed [OutWidth-1:0] result_num,
  output logic signed [OutWidth-1:0] result_den,
  output logic                       gcd_zero
);
  logic [1:0] op;
  logic signed [OPERAND_WIDTH-1:0] na, da, nb, db;
  logic [RawWidth-1:0] p1, p2, n, d, x, y;
  logic [RawWidth-1:0] dv_rem, dv_quo, dv_div;
  logic [CountWidth-1:0] dv_cnt;
  logic dv_neg_q, dv_neg_r;
  logic flag;
  logic signed [2*OPERAND_WIDTH-1:0] prod_a, prod_b;
  logic [RawWidth-1:0] mag_src, mag_y, mag_d, dv_rem_next, shifted;
  logic [RawWidth-1:0] rem_out, quo_out;

  always_comb begin
    prod_a = 'sh0;
    prod_b = 'sh0;
    unique case (func_t'(op))
      FUNC_ADD, FUNC_SUB: begin
        prod_a = na * db;
        prod_b = cmd.mul2 ? da * db : nb * da;
      end
      FUNC_MUL: begin
        prod_a = na * nb;
        prod_b = da * db;
      end
      FUNC_DIV: begin
        prod_a = na * db;
        prod_b = da * nb;
      end
      default: begin
        prod_a = 'sh0;
        prod_b = 'sh0;
      end
    endcase
  end

  always_comb begin
    mag_src = x;
    mag_d = y;
    if (cmd.div_init_num) begin
      mag_src = n;
      mag_d = x;
    end else if (cmd.div_init_den) begin
      mag_src = d;
      mag_d = x;
    end
    mag_y = mag_d[RawWidth-1] ? (~mag_d + 1'b1) : mag_d;
    shifted = {dv_rem[RawWidth-2:0], dv_quo[RawWidth-1]};
    dv_rem_next = shifted - dv_div;
    rem_out = dv_neg_r ? (~dv_rem + 1'b1) : dv_rem;
    quo_out = dv_neg_q ? (~dv_quo + 1'b1) : dv_quo;
  end

  assign status.y_zero = (y == '0);
  assign status.g_zero = (x == '0);
  assign status.g_one = (x == RawWidth'(1));
  assign status.div_done = (dv_cnt == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= func;
      na <= num_a;
      da <= den_a;
      nb <= num_b;
      db <= den_b;
      flag <= 1'b0;
    end
    if (cmd.mul1) begin
      p1 <= RawWidth'(prod_a);
      p2 <= RawWidth'(prod_b);
    end
    if (cmd.mul2) begin
      unique case (func_t'(op))
        FUNC_ADD: begin
          p1 <= p1 + p2;
          p2 <= RawWidth'(prod_b);
        end
        FUNC_SUB: begin
          p1 <= p1 - p2;
          p2 <= RawWidth'(prod_b);
        end
        default: ;
      endcase
    end
    if (cmd.comb) begin
      n <= p1;
      d <= p2;
      x <= p1;
      y <= p2;
    end
    if (cmd.div_init_rem || cmd.div_init_num || cmd.div_init_den) begin
      dv_rem <= '0;
      dv_quo <= mag_src[RawWidth-1] ? (~mag_src + 1'b1) : mag_src;
      dv_div <= mag_y;
      dv_cnt <= CountWidth'(RawWidth);
      dv_neg_r <= mag_src[RawWidth-1];
      dv_neg_q <= mag_src[RawWidth-1] ^ mag_d[RawWidth-1];
    end else if (cmd.div_step) begin
      if (!dv_rem_next[RawWidth-1] || shifted >= dv_div) begin
        if (shifted >= dv_div) begin
          dv_rem <= dv_rem_next;
          dv_quo <= {dv_quo[RawWidth-2:0], 1'b1};
        end else begin
          dv_rem <= shifted;
          dv_quo <= {dv_quo[RawWidth-2:0], 1'b0};
        end
      end else begin
        dv_rem <= shifted;
        dv_quo <= {dv_quo[RawWidth-2:0], 1'b0};
      end
      dv_cnt <= dv_cnt - 1'b1;
    end
    if (cmd.euclid_swap) begin
      x <= y;
      y <= rem_out;
    end
    if (cmd.store_num) n <= quo_out;
    if (cmd.store_den) d <= quo_out;
    if (cmd.set_flag) flag <= 1'b1;
    if (cmd.load_out) begin
      result_num <= n[OutWidth-1:0];
      result_den <= d[OutWidth-1:0];
      gcd_zero <= flag;
    end
    if (rst) dv_cnt <= '0;
  end
endmodule

### hdl/far_ctrl.sv
// Controller state machine sequencing multiply, Euclid and exact divisions.
module far_ctrl
  import far_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  status_t status,
  output cmd_t    cmd
);
  state_t state, state_next;
  logic out_full, out_full_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      out_full <= out_full_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (in_valid) state_next = ST_MUL1;
      ST_MUL1:     state_next = ST_MUL2;
      ST_MUL2:     state_next = ST_COMB;
      ST_COMB:     state_next = ST_TEST;
      ST_TEST:     state_next = status.y_zero ? ST_CHECKG : ST_DIVSTART;
      ST_DIVSTART: state_next = ST_DIVRUN;
      ST_DIVRUN:   if (status.div_done) state_next = ST_EUCLID;
      ST_EUCLID:   state_next = ST_TEST;
      ST_CHECKG: begin
        if (status.g_zero || status.g_one) state_next = ST_OUT;
        else state_next = ST_QNUM;
      end
      ST_QNUM:     state_next = ST_QNUM_RUN;
      ST_QNUM_RUN: if (status.div_done) state_next = ST_QDEN;
      ST_QDEN:     state_next = ST_QDEN_RUN;
      ST_QDEN_RUN: if (status.div_done) state_next = ST_OUT;
      ST_OUT:      if (!out_full || !out_stall) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = (state != ST_IDLE);
    out_full_next = out_full && out_stall;
    unique case (state)
      ST_IDLE:     cmd.load = in_valid;
      ST_MUL1:     cmd.mul1 = 1'b1;
      ST_MUL2:     cmd.mul2 = 1'b1;
      ST_COMB:     cmd.comb = 1'b1;
      ST_DIVSTART: cmd.div_init_rem = 1'b1;
      ST_DIVRUN:   cmd.div_step = !status.div_done;
      ST_EUCLID:   cmd.euclid_swap = 1'b1;
      ST_CHECKG:   cmd.set_flag = status.g_zero;
      ST_QNUM:     cmd.div_init_num = 1'b1;
      ST_QNUM_RUN: begin
        cmd.div_step = !status.div_done;
        cmd.store_num = status.div_done;
        cmd.div_init_den = 1'b0;
      end
      ST_QDEN:     cmd.div_init_den = 1'b1;
      ST_QDEN_RUN: begin
        cmd.div_step = !status.div_done;
        cmd.store_den = status.div_done;
      end
      ST_OUT: begin
        if (!out_full || !out_stall) begin
          cmd.load_out = 1'b1;
          out_full_next = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

  assign out_valid = out_full;

`ifndef SYNTHESIS
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> state == ST_IDLE) else $error("load outside idle");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_full && out_stall) |=> out_full) else $error("result dropped");
  a_step_count: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> !status.div_done) else $error("divider overrun");
`endif
endmodule

### test/fraction_arithmetic_reduce_checker.sv
// Checker for the fraction arithmetic reduce block: predicts reduced fractions and compares.
module fraction_arithmetic_reduce_checker
  import far_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_stall,
  input  logic [1:0] func,
  input  logic signed [15:0] num_a,
  input  logic signed [15:0] den_a,
  input  logic signed [15:0] num_b,
  input  logic signed [15:0] den_b,
  input  logic out_valid,
  input  logic out_stall,
  input  logic signed [OutWidth-1:0] result_num,
  input  logic signed [OutWidth-1:0] result_den,
  input  logic gcd_zero,
  output int errors,
  output int pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [OutWidth-1:0] num;
    logic signed [OutWidth-1:0] den;
    logic zero_flag;
  } fraction_t;

  fraction_t expected_q[$];

  function automatic fraction_t reduce_fraction(func_t op, logic signed [15:0] na,
      logic signed [15:0] da, logic signed [15:0] nb, logic signed [15:0] db);
    longint n, d, x, y, r, g;
    fraction_t res;
    case (op)
      FUNC_ADD: begin n = longint'(na) * db + longint'(nb) * da; d = longint'(da) * db; end
      FUNC_SUB: begin n = longint'(na) * db - longint'(nb) * da; d = longint'(da) * db; end
      FUNC_MUL: begin n = longint'(na) * nb; d = longint'(da) * db; end
      default:  begin n = longint'(na) * db; d = longint'(da) * nb; end
    endcase
    x = n;
    y = d;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    g = x;
    res.zero_flag = (g == 0);
    if (g != 0 && g != 1) begin
      n = n / g;
      d = d / g;
    end
    res.num = n[OutWidth-1:0];
    res.den = d[OutWidth-1:0];
    return res;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    fraction_t exp_r;
    if (rst) begin
      errors <= 0;
    end else begin
      if (in_valid && !in_stall)
        expected_q.push_back(reduce_fraction(func_t'(func), num_a, den_a, num_b, den_b));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("unexpected transfer num=%0d den=%0d", result_num, result_den);
          errors <= errors + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (result_num !== exp_r.num || result_den !== exp_r.den ||
              gcd_zero !== exp_r.zero_flag) begin
            if (result_num !== exp_r.num)
              $error("result_num expected %0d actual %0d", exp_r.num, result_num);
            if (result_den !== exp_r.den)
              $error("result_den expected %0d actual %0d", exp_r.den, result_den);
            if (gcd_zero !== exp_r.zero_flag)
              $error("gcd_zero expected %0d actual %0d", exp_r.zero_flag, gcd_zero);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

### test/fraction_arithmetic_reduce_top_tb.sv
// Testbench top for the fraction arithmetic reduce block: stimulus, stalls and verdict.
module fraction_arithmetic_reduce_top_tb;
  import far_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomItems = 300;
  localparam int IdleLimit = 40000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] func = FUNC_ADD;
  logic signed [15:0] num_a = '0, den_a = '0, num_b = '0, den_b = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [OutWidth-1:0] result_num, result_den;
  logic gcd_zero;
  int errors, pending;
  int idle_cycles = 0;
  bit hold_off = 1'b0;

  always #5 clk = ~clk;

  fraction_arithmetic_reduce_top u_top (.*);

  fraction_arithmetic_reduce_checker u_checker (.*);

  function automatic logic [15:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return 16'(int'($urandom_range(0, 6)) - 3);
      4, 5: return 16'(int'($urandom_range(0, 40)) - 20);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send(func_t op, logic [15:0] na, logic [15:0] da, logic [15:0] nb,
      logic [15:0] db);
    in_valid <= 1'b1;
    func <= op;
    num_a <= na;
    den_a <= da;
    num_b <= nb;
    den_b <= db;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic gap();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 5)) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst || hold_off) out_stall <= hold_off;
    else out_stall <= ($urandom_range(0, 3) == 0);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("fraction_arithmetic_reduce_top test failed");
      $finish;
    end
  end

  initial begin
    int burst;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send(FUNC_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd3);
    send(FUNC_SUB, 16'sd1, 16'sd2, 16'sd1, 16'sd2);
    send(FUNC_MUL, 16'sd0, 16'sd0, 16'sd5, 16'sd0);
    send(FUNC_DIV, 16'sd3, 16'sd0, 16'sd4, 16'sd7);
    send(FUNC_MUL, 16'sd3, 16'sd0, 16'sd4, 16'sd7);
    send(FUNC_MUL, 16'sd0, 16'sd5, 16'sd4, 16'sd7);
    send(FUNC_ADD, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send(FUNC_SUB, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
    send(FUNC_MUL, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
    send(FUNC_DIV, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send(FUNC_DIV, -16'sd6, 16'sd4, 16'sd3, -16'sd9);
    send(FUNC_ADD, -16'sd1, -16'sd1, -16'sd1, -16'sd1);
    send(FUNC_MUL, 16'shffff, 16'sh5555, 16'shaaaa, 16'sh0001);
    gap();
    hold_off <= 1'b1;
    fork
      begin
        repeat (3000) @(posedge clk);
        hold_off <= 1'b0;
      end
      repeat (6) send(func_t'($urandom_range(0, 3)), pick_operand(), pick_operand(),
                      pick_operand(), pick_operand());
    join
    for (int i = 0; i < RandomItems; ) begin
      burst = $urandom_range(1, 8);
      for (int k = 0; k < burst && i < RandomItems; k++, i++)
        send(func_t'($urandom_range(0, 3)), pick_operand(), pick_operand(),
             pick_operand(), pick_operand());
      gap();
    end
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("fraction_arithmetic_reduce_top test passed");
    else $display("fraction_arithmetic_reduce_top test failed");
    $finish;
  end
endmodule
